[sv/rkwlex_pkg.sv]
package rkwlex_pkg;

    // Source beat: one character or an end marker
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } rkwlex_in_t;

    // Token beat
    typedef struct packed {
        logic [3:0] token_kind;
        logic [1:0] keyword_index;
        logic [7:0] text_char;
        logic       truncated;
        logic       last;
    } rkwlex_out_t;

    // Token kinds
    localparam logic [3:0] KIND_SEP     = 4'd0;
    localparam logic [3:0] KIND_LT      = 4'd1;
    localparam logic [3:0] KIND_LE      = 4'd2;
    localparam logic [3:0] KIND_GT      = 4'd3;
    localparam logic [3:0] KIND_GE      = 4'd4;
    localparam logic [3:0] KIND_NE      = 4'd5;
    localparam logic [3:0] KIND_BANG    = 4'd6;
    localparam logic [3:0] KIND_KEYWORD = 4'd7;
    localparam logic [3:0] KIND_IDENT   = 4'd8;

    // Characters of interest
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NL    = 8'h0A;

    // Keyword registers, one 64-bit register per 8-byte slot
    localparam int NUM_KEYWORDS = 4;
    localparam int KW_WIDTH     = 64;
    localparam int REG_SEL_LSB  = 3;
    localparam int ADDR_W       = REG_SEL_LSB + $clog2(NUM_KEYWORDS);

    localparam logic [KW_WIDTH-1:0] KW0_RESET = 64'd7630441;       // "int"
    localparam logic [KW_WIDTH-1:0] KW1_RESET = 64'd499850898534;  // "float"
    localparam logic [KW_WIDTH-1:0] KW2_RESET = 64'd26217;         // "if"
    localparam logic [KW_WIDTH-1:0] KW3_RESET = 64'd1702063205;    // "else"

    typedef logic [NUM_KEYWORDS-1:0][KW_WIDTH-1:0] rkwlex_kw_t;

    // Command queue between classifier and token engine
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic       tok_a_en;    // emit an operator or separator token
        logic [3:0] tok_a_kind;
        logic       tok_b_en;    // then a separator token
        logic       flush;       // close the current word
        logic       store;       // append ch to the word
        logic       start;       // ch opens a new word
        logic [7:0] ch;
    } rkwlex_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rkwlex_qstat_t;

    function automatic logic is_letter(input logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        return (l >= 8'h61) && (l <= 8'h7A);
    endfunction

endpackage

[sv/rkwlex_front.sv]
module rkwlex_front
    import rkwlex_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          src_valid,
    input  rkwlex_in_t    src_beat,
    output logic          src_stall,
    input  rkwlex_qstat_t q_stat,
    output logic          q_push,
    output rkwlex_cmd_t   q_cmd
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_LT   = 5'b00010,
        M_GT   = 5'b00100,
        M_BANG = 5'b01000,
        M_WORD = 5'b10000
    } front_mode_t;

    front_mode_t mode_reg, mode_next;
    rkwlex_cmd_t cmd;
    logic        accept;

    assign src_stall = q_stat.full;
    assign accept    = src_valid && !q_stat.full;

    // Classify one beat against the pending operator / word mode
    always_comb
    begin
        logic [7:0] c;
        logic       idle_pass;
        c         = src_beat.char_in;
        idle_pass = 1'b0;
        cmd       = '0;
        cmd.ch    = c;
        mode_next = mode_reg;

        if (src_beat.end_of_input)
        begin
            mode_next = M_IDLE;
            case (mode_reg)
                M_LT:
                begin
                    cmd.tok_a_en   = 1'b1;
                    cmd.tok_a_kind = KIND_LT;
                end
                M_GT:
                begin
                    cmd.tok_a_en   = 1'b1;
                    cmd.tok_a_kind = KIND_GT;
                end
                M_BANG:
                begin
                    cmd.tok_a_en   = 1'b1;
                    cmd.tok_a_kind = KIND_BANG;
                end
                M_WORD:  cmd.flush = 1'b1;
                default: ;
            endcase
        end
        else
        begin
            case (mode_reg)
                M_LT, M_GT, M_BANG:
                begin
                    cmd.tok_a_en = 1'b1;
                    mode_next    = M_IDLE;
                    if (c == CHAR_EQ)
                    begin
                        cmd.tok_a_kind = (mode_reg == M_LT) ? KIND_LE :
                                         (mode_reg == M_GT) ? KIND_GE : KIND_NE;
                    end
                    else
                    begin
                        cmd.tok_a_kind = (mode_reg == M_LT) ? KIND_LT :
                                         (mode_reg == M_GT) ? KIND_GT : KIND_BANG;
                        idle_pass      = 1'b1;
                    end
                end
                M_WORD:
                begin
                    if (c == CHAR_SPACE || c == CHAR_NL)
                    begin
                        cmd.flush = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
                default: idle_pass = 1'b1;
            endcase

            // Character seen as if idle (also the put-back case)
            if (idle_pass)
            begin
                mode_next = M_IDLE;
                if (c == CHAR_LT)
                begin
                    mode_next = M_LT;
                end
                else if (c == CHAR_GT)
                begin
                    mode_next = M_GT;
                end
                else if (c == CHAR_BANG)
                begin
                    mode_next = M_BANG;
                end
                else if (is_letter(c))
                begin
                    cmd.store = 1'b1;
                    cmd.start = 1'b1;
                    mode_next = M_WORD;
                end
                else if (cmd.tok_a_en)
                begin
                    cmd.tok_b_en = 1'b1;
                end
                else
                begin
                    cmd.tok_a_en   = 1'b1;
                    cmd.tok_a_kind = KIND_SEP;
                end
            end
        end
    end

    // Only beats that leave work for the back end go into the queue
    assign q_cmd  = cmd;
    assign q_push = accept && (cmd.tok_a_en || cmd.flush || cmd.store);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

[sv/rkwlex_queue.sv]
module rkwlex_queue
    import rkwlex_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rkwlex_cmd_t   push_cmd,
    input  logic          pop,
    output rkwlex_cmd_t   head,
    output rkwlex_qstat_t stat
);

    localparam int PTRW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    rkwlex_cmd_t     entry_reg [QUEUE_DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic            do_push, do_pop;

    assign stat.full  = (count_reg == CNTW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 :
                              PTRW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 :
                              PTRW'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= CNTW'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= CNTW'(count_reg - 1'b1);
            end
        end
    end

endmodule

[sv/rkwlex_back.sv]
module rkwlex_back
    import rkwlex_pkg::*;
#(
    parameter int WORD_CAPACITY = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  rkwlex_qstat_t q_stat,
    input  rkwlex_cmd_t   q_head,
    output logic          q_pop,
    input  rkwlex_kw_t    kw,
    output logic          tok_valid,
    input  logic          tok_stall,
    output rkwlex_out_t   tok_beat
);

    localparam int LENW = $clog2(WORD_CAPACITY + 1);
    localparam int IDXW = $clog2(WORD_CAPACITY);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_TOKA  = 5'b00010,
        B_TOKB  = 5'b00100,
        B_MATCH = 5'b01000,
        B_IDENT = 5'b10000
    } back_state_t;

    back_state_t       state_reg, state_next;
    rkwlex_cmd_t       cmd_reg, cmd_next;
    logic [LENW-1:0]   len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic [63:0]       pack_reg, pack_next;
    logic [IDXW-1:0]   idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    rkwlex_out_t       out_beat_reg, out_beat_next;
    logic [7:0]        rd_char_reg;
    logic [7:0]        word_mem [WORD_CAPACITY];

    logic              out_load;
    logic              wr_en, rd_en;
    logic [IDXW-1:0]   wr_addr, rd_addr;
    logic              kw_hit;
    logic [1:0]        kw_idx;
    logic              ident_last;

    assign out_load   = !out_valid_reg || !tok_stall;
    assign tok_valid  = out_valid_reg;
    assign tok_beat   = out_beat_reg;
    assign ident_last = (LENW'(idx_reg) == LENW'(len_reg - 1'b1));

    // Keyword compare, lowest register wins
    always_comb
    begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--)
        begin
            if (kw[k] == pack_reg)
            begin
                kw_hit = 1'b1;
                kw_idx = 2'(k);
            end
        end
        if (ovf_reg || len_reg > LENW'(8))
        begin
            kw_hit = 1'b0;
        end
    end

    // Command sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        pack_next      = pack_reg;
        idx_next       = idx_reg;
        out_valid_next = out_load ? 1'b0 : out_valid_reg;
        out_beat_next  = out_beat_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    // word append takes effect at pop; it yields no token
                    if (q_head.store)
                    begin
                        if (q_head.start)
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = '0;
                            len_next  = LENW'(1);
                            ovf_next  = 1'b0;
                            pack_next = {56'd0, q_head.ch};
                        end
                        else if (len_reg < LENW'(WORD_CAPACITY))
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = len_reg[IDXW-1:0];
                            len_next = LENW'(len_reg + 1'b1);
                            for (int b = 0; b < 8; b++)
                            begin
                                if (len_reg == LENW'(b))
                                begin
                                    pack_next[8*b +: 8] = q_head.ch;
                                end
                            end
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (q_head.tok_a_en)
                    begin
                        state_next = B_TOKA;
                    end
                    else if (q_head.flush)
                    begin
                        state_next = B_MATCH;
                    end
                end
            end
            B_TOKA:
            begin
                if (out_load)
                begin
                    out_valid_next            = 1'b1;
                    out_beat_next             = '0;
                    out_beat_next.token_kind  = cmd_reg.tok_a_kind;
                    out_beat_next.last        = !cmd_reg.tok_b_en;
                    state_next = cmd_reg.tok_b_en ? B_TOKB : B_IDLE;
                end
            end
            B_TOKB:
            begin
                if (out_load)
                begin
                    out_valid_next           = 1'b1;
                    out_beat_next            = '0;
                    out_beat_next.token_kind = KIND_SEP;
                    out_beat_next.last       = 1'b1;
                    state_next               = B_IDLE;
                end
            end
            B_MATCH:
            begin
                if (kw_hit)
                begin
                    if (out_load)
                    begin
                        out_valid_next              = 1'b1;
                        out_beat_next               = '0;
                        out_beat_next.token_kind    = KIND_KEYWORD;
                        out_beat_next.keyword_index = kw_idx;
                        out_beat_next.last          = 1'b1;
                        len_next                    = '0;
                        ovf_next                    = 1'b0;
                        state_next                  = B_IDLE;
                    end
                end
                else
                begin
                    // fetch the first stored character
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    state_next = B_IDENT;
                end
            end
            B_IDENT:
            begin
                if (out_load)
                begin
                    out_valid_next           = 1'b1;
                    out_beat_next            = '0;
                    out_beat_next.token_kind = KIND_IDENT;
                    out_beat_next.text_char  = rd_char_reg;
                    out_beat_next.truncated  = ovf_reg;
                    out_beat_next.last       = ident_last;
                    if (ident_last)
                    begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next = IDXW'(idx_reg + 1'b1);
                        rd_en    = 1'b1;
                        rd_addr  = IDXW'(idx_reg + 1'b1);
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Word store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            word_mem[wr_addr] <= cmd_next.ch;
        end
        if (rd_en)
        begin
            rd_char_reg <= word_mem[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pack_reg     <= pack_next;
        idx_reg      <= idx_next;
        out_beat_reg <= out_beat_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/relop_keyword_identifier_lexer_core.sv]
// Relational-operator, keyword and identifier lexer.
// Source channel (src_valid / src_stall / src_beat): one character or an
// end-of-input marker per beat. Token channel (tok_valid / tok_stall /
// tok_beat): zero or more tokens per source beat, the final one with last set.
// Four 64-bit keyword registers sit on the APB port at byte addresses 0, 8,
// 16 and 24; write them only while the lexer is quiet.
// A classifier accepts one source beat per cycle while its 4-entry command
// queue has room; src_stall is the queue-full flag. The token engine behind
// the queue pops a command while idle, then issues its tokens one at a time.
// Closing a word goes through a compare state, which on a keyword miss also
// issues the first word-store read; an identifier then gives one token per
// stored character. While tok_stall is high the output register holds its
// beat and the queue fills; once full, src_stall rises. Reset clears the
// scan mode, the word length, the queue and the output valid, and loads the
// default keywords (int, float, if, else). The word store needs no clearing.
module relop_keyword_identifier_lexer_core
    import rkwlex_pkg::*;
#(
    parameter int WORD_CAPACITY = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  rkwlex_in_t          src_beat,
    output logic                tok_valid,
    input  logic                tok_stall,
    output rkwlex_out_t         tok_beat,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [KW_WIDTH-1:0] pwdata,
    output logic [KW_WIDTH-1:0] prdata,
    output logic                pready
);

    rkwlex_kw_t    kw_reg;
    rkwlex_qstat_t q_stat;
    rkwlex_cmd_t   q_cmd, q_head;
    logic          q_push, q_pop;
    logic [$clog2(NUM_KEYWORDS)-1:0] reg_sel;

    // Register file access
    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1:REG_SEL_LSB];
    assign prdata  = kw_reg[reg_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_reg[0] <= KW0_RESET;
            kw_reg[1] <= KW1_RESET;
            kw_reg[2] <= KW2_RESET;
            kw_reg[3] <= KW3_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            kw_reg[reg_sel] <= pwdata;
        end
    end

    rkwlex_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_beat  (src_beat),
        .src_stall (src_stall),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    rkwlex_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    rkwlex_back #(
        .WORD_CAPACITY (WORD_CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .kw        (kw_reg),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_beat  (tok_beat)
    );

endmodule

[sv/rkwlex_checker.sv]
module rkwlex_checker
    import rkwlex_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        tok_valid,
    input logic        tok_stall,
    input rkwlex_out_t tok_beat,
    input logic        pready
);

    // Register port never waits
    a_pready: assert property (@(posedge clk) pready)
        else $error("pready dropped");

    // No token beat while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !tok_valid)
        else $error("token beat during reset");

    // A stalled token beat is held
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(tok_beat))
        else $error("stalled token beat changed");

    // Token kinds stay in range
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> tok_beat.token_kind <= KIND_IDENT)
        else $error("token kind out of range");

    // Only identifier beats carry text or a truncation flag
    a_text: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_beat.token_kind != KIND_IDENT
        |-> tok_beat.text_char == 8'd0 && !tok_beat.truncated)
        else $error("text on a non-identifier token");

endmodule

bind relop_keyword_identifier_lexer_core rkwlex_checker u_rkwlex_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_beat  (tok_beat),
    .pready    (pready)
);

[bench/relop_keyword_identifier_lexer_core_tb.sv]
module relop_keyword_identifier_lexer_core_tb;
    import rkwlex_pkg::*;

    localparam int WORD_CAP      = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 150;

    typedef enum logic [2:0] {SCAN_IDLE, SCAN_LT, SCAN_GT, SCAN_BANG, SCAN_WORD} scan_mode_t;

    logic                clk;
    logic                rst_n;
    logic                src_valid;
    logic                src_stall;
    rkwlex_in_t          src_beat;
    logic                tok_valid;
    logic                tok_stall;
    rkwlex_out_t         tok_beat;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [KW_WIDTH-1:0] pwdata;
    logic [KW_WIDTH-1:0] prdata;
    logic                pready;

    // Lexer state as the bench sees it
    scan_mode_t          scan_mode;
    logic [7:0]          word_buf [WORD_CAP];
    int                  word_len;
    logic                word_ovf;
    logic [KW_WIDTH-1:0] keywords [NUM_KEYWORDS];

    // Tokens still owed by the lexer, oldest first
    rkwlex_out_t         expected_tokens [$];
    rkwlex_out_t         step_tokens [$];

    int                  error_count;
    int                  quiet_cycles;
    int                  beats_sent;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_left;

    relop_keyword_identifier_lexer_core #(
        .WORD_CAPACITY(WORD_CAP)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_beat  (src_beat),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_beat  (tok_beat),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_error(string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // ---------------------------------------------------------------
    // Token prediction
    // ---------------------------------------------------------------
    function automatic void reset_lexer_state();
        keywords[0] = KW0_RESET;
        keywords[1] = KW1_RESET;
        keywords[2] = KW2_RESET;
        keywords[3] = KW3_RESET;
        scan_mode = SCAN_IDLE;
        word_len = 0;
        word_ovf = 1'b0;
        foreach (word_buf[i])
            word_buf[i] = 8'h00;
    endfunction

    function automatic bit letter_byte(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic void push_token(logic [3:0] kind, logic [1:0] idx, logic [7:0] ch,
                                       logic trunc);
        rkwlex_out_t t;
        t.token_kind    = kind;
        t.keyword_index = idx;
        t.text_char     = ch;
        t.truncated     = trunc;
        t.last          = 1'b0;
        step_tokens.push_back(t);
    endfunction

    // Kind for a held operator, either paired with '=' or alone
    function automatic logic [3:0] op_kind(scan_mode_t held, bit paired);
        case (held)
            SCAN_LT: return paired ? KIND_LE : KIND_LT;
            SCAN_GT: return paired ? KIND_GE : KIND_GT;
            default: return paired ? KIND_NE : KIND_BANG;
        endcase
    endfunction

    function automatic void lex_idle(logic [7:0] c);
        if (c == CHAR_LT)
            scan_mode = SCAN_LT;
        else if (c == CHAR_GT)
            scan_mode = SCAN_GT;
        else if (c == CHAR_BANG)
            scan_mode = SCAN_BANG;
        else if (letter_byte(c))
        begin
            word_buf[0] = c;
            word_len = 1;
            word_ovf = 1'b0;
            scan_mode = SCAN_WORD;
        end
        else
            push_token(KIND_SEP, 2'd0, 8'd0, 1'b0);
    endfunction

    // Keyword lookup, else spell the word out one character per token
    function automatic void close_word();
        logic [63:0] packed_word;
        bit          hit;
        packed_word = '0;
        hit = 1'b0;
        if (!word_ovf && word_len <= 8)
        begin
            for (int i = 0; i < word_len; i++)
                packed_word |= 64'(word_buf[i]) << (8 * i);
            for (int k = 0; k < NUM_KEYWORDS && !hit; k++)
            begin
                if (keywords[k] == packed_word)
                begin
                    push_token(KIND_KEYWORD, 2'(k), 8'd0, 1'b0);
                    hit = 1'b1;
                end
            end
        end
        if (!hit)
            for (int i = 0; i < word_len; i++)
                push_token(KIND_IDENT, 2'd0, word_buf[i], word_ovf);
        word_len = 0;
        word_ovf = 1'b0;
        scan_mode = SCAN_IDLE;
    endfunction

    function automatic void lex_beat(rkwlex_in_t b);
        logic [7:0]  c;
        scan_mode_t  held;
        rkwlex_out_t t;
        c = b.char_in;
        held = scan_mode;
        step_tokens.delete();
        if (b.end_of_input)
        begin
            if (held == SCAN_WORD)
                close_word();
            else if (held != SCAN_IDLE)
                push_token(op_kind(held, 1'b0), 2'd0, 8'd0, 1'b0);
            scan_mode = SCAN_IDLE;
            word_len = 0;
            word_ovf = 1'b0;
        end
        else if (held == SCAN_WORD)
        begin
            if (c == CHAR_SPACE || c == CHAR_NL)
                close_word();
            else if (word_len < WORD_CAP)
            begin
                word_buf[word_len] = c;
                word_len++;
            end
            else
                word_ovf = 1'b1;
        end
        else if (held == SCAN_IDLE)
            lex_idle(c);
        else
        begin
            // held operator: pair with '=' or put the byte back
            scan_mode = SCAN_IDLE;
            push_token(op_kind(held, c == CHAR_EQ), 2'd0, 8'd0, 1'b0);
            if (c != CHAR_EQ)
                lex_idle(c);
        end
        if (step_tokens.size() != 0)
        begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
        end
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endfunction

    // ---------------------------------------------------------------
    // Source side: one beat per call, entered and left at a falling edge
    // ---------------------------------------------------------------
    task automatic send_beat(logic [7:0] c, logic eoi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_beat <= '{char_in: c, end_of_input: eoi};
        do
            @(posedge clk);
        while (src_stall);
        lex_beat(src_beat);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    function automatic logic [7:0] random_letter();
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
    endfunction

    // A word, often one of the current keywords, then its terminator
    task automatic send_word(int min_len, int max_len);
        logic [7:0] text [$];
        logic [7:0] c;
        int         len;
        int         k;
        k = $urandom_range(NUM_KEYWORDS - 1);
        if ($urandom_range(99) < 40 && letter_byte(keywords[k][7:0]))
        begin
            for (int i = 0; i < 8 && keywords[k][8*i +: 8] != 8'h00; i++)
                text.push_back(keywords[k][8*i +: 8]);
            // near miss now and then
            if ($urandom_range(3) == 0)
                text.push_back(random_letter());
        end
        else
        begin
            len = $urandom_range(max_len, min_len);
            text.push_back(random_letter());
            while (text.size() < len)
            begin
                if ($urandom_range(99) < 80)
                    c = random_letter();
                else
                begin
                    c = 8'($urandom_range(255));
                    if (c == CHAR_SPACE || c == CHAR_NL)
                        c = 8'h5F;
                end
                text.push_back(c);
            end
        end
        foreach (text[i])
            send_beat(text[i], 1'b0);
        case ($urandom_range(9))
            0:             send_beat(8'($urandom_range(255)), 1'b1);
            1, 2, 3, 4, 5: send_beat(CHAR_SPACE, 1'b0);
            default:       send_beat(CHAR_NL, 1'b0);
        endcase
    endtask

    // Mostly well-formed source text with some raw noise mixed in
    task automatic send_lexemes(int n_beats, int min_len, int max_len);
        int         target;
        int         pick;
        logic [7:0] c;
        target = beats_sent + n_beats;
        while (beats_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_word(min_len, max_len);
            else if (pick < 60)
            begin
                case ($urandom_range(2))
                    0:       send_beat(CHAR_LT, 1'b0);
                    1:       send_beat(CHAR_GT, 1'b0);
                    default: send_beat(CHAR_BANG, 1'b0);
                endcase
                if ($urandom_range(1))
                    send_beat(CHAR_EQ, 1'b0);
            end
            else if (pick < 72)
            begin
                do
                    c = 8'($urandom_range(8'h7F, 8'h20));
                while (letter_byte(c));
                send_beat(c, 1'b0);
            end
            else if (pick < 88)
                send_beat(8'($urandom_range(255)), 1'b0);
            else
                send_beat(8'($urandom_range(255)), 1'b1);
        end
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    // Drop valid, let every owed token arrive, then let the lexer settle
    task automatic wait_quiet();
        src_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    task automatic apb_write(int idx, logic [KW_WIDTH-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * idx);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        keywords[idx] = value;
        @(negedge clk);
    endtask

    task automatic apb_read_check(int idx);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_W'(8 * idx);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== keywords[idx])
            report_error($sformatf("keyword_%0d reads %h, expected %h", idx, prdata,
                                   keywords[idx]));
        @(negedge clk);
    endtask

    task automatic apb_release();
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_keywords(logic [KW_WIDTH-1:0] k0, logic [KW_WIDTH-1:0] k1,
                                 logic [KW_WIDTH-1:0] k2, logic [KW_WIDTH-1:0] k3);
        apb_write(0, k0);
        apb_write(1, k1);
        apb_write(2, k2);
        apb_write(3, k3);
        for (int i = 0; i < NUM_KEYWORDS; i++)
            apb_read_check(i);
        apb_release();
    endtask

    function automatic logic [KW_WIDTH-1:0] random_keyword(int len);
        logic [KW_WIDTH-1:0] kw;
        kw = '0;
        for (int i = 0; i < len; i++)
            kw[8*i +: 8] = 8'h61 + 8'($urandom_range(25));
        return kw;
    endfunction

    // ---------------------------------------------------------------
    // Token side: stall, hold-off and checking
    // ---------------------------------------------------------------
    initial
    begin
        tok_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                tok_stall <= 1'b1;
            end
            else
                tok_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic check_token(rkwlex_out_t got);
        rkwlex_out_t want;
        if (expected_tokens.size() == 0)
        begin
            report_error($sformatf("token kind %0d with nothing owed", got.token_kind));
            return;
        end
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind)
            report_error($sformatf("token_kind %0d, expected %0d", got.token_kind,
                                   want.token_kind));
        if (got.keyword_index !== want.keyword_index)
            report_error($sformatf("keyword_index %0d, expected %0d", got.keyword_index,
                                   want.keyword_index));
        if (got.text_char !== want.text_char)
            report_error($sformatf("text_char %h, expected %h", got.text_char,
                                   want.text_char));
        if (got.truncated !== want.truncated)
            report_error($sformatf("truncated %b, expected %b", got.truncated,
                                   want.truncated));
        if (got.last !== want.last)
            report_error($sformatf("last %b, expected %b", got.last, want.last));
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && tok_valid && !tok_stall)
                check_token(tok_beat);
        end
    end

    // Watchdog: ends the run after a long stretch with no beat on either side
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_reset_keywords();
        for (int i = 0; i < NUM_KEYWORDS; i++)
            apb_read_check(i);
        apb_release();
    endtask

    // Operators, put-back, extremes, end of input in every mode
    task automatic test_directed_tokens();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_text("<=>=!=><!A");
        send_beat(8'h00, 1'b0);
        send_beat(CHAR_NL, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(CHAR_BANG, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(CHAR_LT, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(CHAR_GT, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'hFF, 1'b1);
        send_text("if");
        send_beat(8'h20, 1'b1);
        wait_quiet();
    endtask

    task automatic test_default_stream();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_lexemes(15, 1, 10);
        wait_quiet();
    endtask

    // All-ones, zero and a duplicated one-letter keyword
    task automatic test_keyword_extremes();
        load_keywords('1, '0, 64'h61, 64'h61);
        send_idle_pct = 74;
        recv_stall_pct = 0;
        send_text("a b\n");
        send_lexemes(15, 1, 4);
        wait_quiet();
    endtask

    task automatic test_random_keywords();
        logic [KW_WIDTH-1:0] dup;
        dup = random_keyword($urandom_range(8, 1));
        load_keywords(random_keyword(8), dup, dup, random_keyword($urandom_range(7, 1)));
        send_idle_pct = 0;
        recv_stall_pct = 74;
        send_lexemes(15, 1, 9);
        wait_quiet();
    endtask

    // Words at and past capacity
    task automatic test_long_words();
        load_keywords(KW0_RESET, KW1_RESET, KW2_RESET, KW3_RESET);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        send_lexemes(20, 14, 22);
        wait_quiet();
    endtask

    // Receiver holds off while the source keeps offering beats
    task automatic test_back_pressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = HOLD_CYCLES;
        send_lexemes(20, 1, 6);
        wait_quiet();
    endtask

    initial
    begin
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_beat = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        beats_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        reset_lexer_state();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_keywords();
        test_directed_tokens();
        test_default_stream();
        test_keyword_extremes();
        test_random_keywords();
        test_long_words();
        test_back_pressure();

        if (expected_tokens.size() != 0)
            report_error($sformatf("%0d tokens never arrived", expected_tokens.size()));
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
sv/rkwlex_pkg.sv
sv/rkwlex_front.sv
sv/rkwlex_queue.sv
sv/rkwlex_back.sv
sv/relop_keyword_identifier_lexer_core.sv
sv/rkwlex_checker.sv
bench/relop_keyword_identifier_lexer_core_tb.sv
